@@ sv/mwf_pkg.sv @@
// mwf_pkg: shared types and constants of the median window filter
package mwf_pkg;

  typedef logic [7:0] pixel_t;

  // result flags carried down the pipeline with each result
  typedef struct packed {
    logic line_end;
    logic frame_end;
  } mwf_flags_t;

  localparam int IN_ROW_W   = 13;
  localparam int OUT_ROW_W  = 12;
  localparam int HEIGHT_W   = 13;
  localparam int WIDTH_REG_W = 11;
  localparam int MAX_HEIGHT = 4096;
  localparam int RESET_WIDTH = 512;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd512;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

endpackage

@@ sv/mwf_ifs.sv @@
// mwf_ifs: channel interfaces of the median window filter
interface mwf_pix_if;
  import mwf_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t sample;
  logic   drain;
  modport source (output valid, output sample, output drain, input ready);
  modport sink (input valid, input sample, input drain, output ready);
endinterface

interface mwf_res_if;
  import mwf_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t filtered;
  logic   line_end;
  logic   frame_end;
  modport source (output valid, output filtered, output line_end, output frame_end,
                  input ready);
  modport sink (input valid, input filtered, input line_end, input frame_end,
                output ready);
endinterface

interface mwf_cfg_if;
  import mwf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/mwf_line_bank.sv @@
// mwf_line_bank: one bank of the line store, one write and one registered read port
module mwf_line_bank #(
  parameter int DEPTH = 342,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mwf_pkg::pixel_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output mwf_pkg::pixel_t rdata
);
  import mwf_pkg::*;

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/mwf_ctrl.sv @@
// mwf_ctrl: config registers, raster counters, store writes and result scheduling
module mwf_ctrl #(
  parameter int RADIUS = 1,
  parameter int MAX_WIDTH = 1024,
  localparam int SIDE = 2 * RADIUS + 1,
  localparam int LINES = 4 * RADIUS + 2,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = CW + 1,
  localparam int KW = $clog2(SIDE),
  localparam int LW = $clog2(LINES),
  localparam int DEPTH = (MAX_WIDTH + SIDE - 1) / SIDE,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                item_valid,
  input  mwf_pkg::pixel_t                     item_sample,
  input  logic                                item_drain,
  input  logic                                cfg_valid,
  input  logic [mwf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mwf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                wr_en,
  output logic [LW-1:0]                       wr_line,
  output logic [KW-1:0]                       wr_k,
  output logic [AW-1:0]                       wr_addr,
  output mwf_pkg::pixel_t                     wr_data,
  output logic                                pos_valid,
  output logic [mwf_pkg::OUT_ROW_W-1:0]       pos_row,
  output logic [CW-1:0]                       pos_col,
  output logic [AW-1:0]                       pos_q,
  output logic [KW-1:0]                       pos_k,
  output logic [LW-1:0]                       pos_line,
  output mwf_pkg::mwf_flags_t                 pos_flags,
  output logic [WW-1:0]                       w_eff,
  output logic [mwf_pkg::HEIGHT_W-1:0]        h_eff
);
  import mwf_pkg::*;

  localparam logic [WW-1:0] W_RESET =
    (RESET_WIDTH > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(RESET_WIDTH);

  logic [IN_ROW_W-1:0]  in_row, in_row_next;
  logic [CW-1:0]        in_col, in_col_next;
  logic [AW-1:0]        in_q, in_q_next;
  logic [KW-1:0]        in_k, in_k_next;
  logic [LW-1:0]        in_line, in_line_next;
  logic [OUT_ROW_W-1:0] out_row, out_row_next;
  logic [CW-1:0]        out_col, out_col_next;
  logic [AW-1:0]        out_q, out_q_next;
  logic [KW-1:0]        out_k, out_k_next;
  logic [LW-1:0]        out_line, out_line_next;

  logic                 store;
  logic                 in_last;
  logic [13:0]          dr;
  logic [WW-1:0]        dc;
  logic                 emit;
  logic                 last_col;
  logic                 last_frame;
  logic                 cfg_hit;
  logic [WW-1:0]        w_new;
  logic [HEIGHT_W-1:0]  h_new;

  assign cfg_hit = cfg_valid && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // zero and oversize sizes clamp to the supported range; width takes only the low WIDTH_REG_W data bits
  always_comb begin
    if (cfg_data[WIDTH_REG_W-1:0] == '0) begin
      w_new = WW'(1);
    end else if (32'(cfg_data[WIDTH_REG_W-1:0]) > 32'(MAX_WIDTH)) begin
      w_new = WW'(MAX_WIDTH);
    end else begin
      w_new = WW'(cfg_data[WIDTH_REG_W-1:0]);
    end
    if (cfg_data == '0) begin
      h_new = HEIGHT_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      h_new = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_new = cfg_data;
    end
  end

  always_comb begin
    store   = !item_drain && (in_row < h_eff);
    in_last = ({1'b0, in_col} == w_eff - WW'(1));

    in_row_next  = in_row;
    in_col_next  = in_col;
    in_q_next    = in_q;
    in_k_next    = in_k;
    in_line_next = in_line;
    if (store) begin
      if (in_last) begin
        in_row_next  = in_row + IN_ROW_W'(1);
        in_col_next  = '0;
        in_q_next    = '0;
        in_k_next    = '0;
        in_line_next = (in_line == LW'(LINES - 1)) ? '0 : in_line + LW'(1);
      end else begin
        in_col_next = in_col + CW'(1);
        if (in_k == KW'(SIDE - 1)) begin
          in_k_next = '0;
          in_q_next = in_q + AW'(1);
        end else begin
          in_k_next = in_k + KW'(1);
        end
      end
    end

    // last input position the current result waits for
    dr = ({2'b00, out_row} + 14'(RADIUS) > {1'b0, h_eff} - 14'd1)
           ? {1'b0, h_eff} - 14'd1 : {2'b00, out_row} + 14'(RADIUS);
    dc = ({1'b0, out_col} + WW'(RADIUS) > w_eff - WW'(1))
           ? w_eff - WW'(1) : {1'b0, out_col} + WW'(RADIUS);
    emit = ({1'b0, in_row_next} > dr)
        || ({1'b0, in_row_next} == dr && {1'b0, in_col_next} > dc);

    last_col   = ({1'b0, out_col} == w_eff - WW'(1));
    last_frame = last_col && ({1'b0, out_row} == h_eff - HEIGHT_W'(1));

    out_row_next  = out_row;
    out_col_next  = out_col;
    out_q_next    = out_q;
    out_k_next    = out_k;
    out_line_next = out_line;
    if (emit) begin
      if (last_frame) begin
        out_row_next  = '0;
        out_col_next  = '0;
        out_q_next    = '0;
        out_k_next    = '0;
        out_line_next = '0;
        in_row_next   = '0;
        in_col_next   = '0;
        in_q_next     = '0;
        in_k_next     = '0;
        in_line_next  = '0;
      end else if (last_col) begin
        out_row_next  = out_row + OUT_ROW_W'(1);
        out_col_next  = '0;
        out_q_next    = '0;
        out_k_next    = '0;
        out_line_next = (out_line == LW'(LINES - 1)) ? '0 : out_line + LW'(1);
      end else begin
        out_col_next = out_col + CW'(1);
        if (out_k == KW'(SIDE - 1)) begin
          out_k_next = '0;
          out_q_next = out_q + AW'(1);
        end else begin
          out_k_next = out_k + KW'(1);
        end
      end
    end
  end

  assign wr_en   = adv && item_valid && store;
  assign wr_line = in_line;
  assign wr_k    = in_k;
  assign wr_addr = in_q;
  assign wr_data = item_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff    <= W_RESET;
      h_eff    <= RESET_HEIGHT;
      in_row   <= '0;
      in_col   <= '0;
      in_q     <= '0;
      in_k     <= '0;
      in_line  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_q    <= '0;
      out_k    <= '0;
      out_line <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        w_eff <= w_new;
      end else begin
        h_eff <= h_new;
      end
      // any size write aborts the frame in progress
      in_row   <= '0;
      in_col   <= '0;
      in_q     <= '0;
      in_k     <= '0;
      in_line  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_q    <= '0;
      out_k    <= '0;
      out_line <= '0;
    end else if (adv && item_valid) begin
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_q     <= in_q_next;
      in_k     <= in_k_next;
      in_line  <= in_line_next;
      out_row  <= out_row_next;
      out_col  <= out_col_next;
      out_q    <= out_q_next;
      out_k    <= out_k_next;
      out_line <= out_line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid <= 1'b0;
    end else if (adv) begin
      pos_valid <= item_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_row             <= out_row;
      pos_col             <= out_col;
      pos_q               <= out_q;
      pos_k               <= out_k;
      pos_line            <= out_line;
      pos_flags.line_end  <= last_col;
      pos_flags.frame_end <= last_frame;
    end
  end

  a_in_row_bound: assert property (@(posedge clk) disable iff (rst) in_row <= h_eff)
    else $error("input row beyond frame height");
  a_out_pos_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, out_row} < h_eff) && ({1'b0, out_col} < w_eff))
    else $error("result position outside the frame");
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    (in_k < KW'(SIDE)) && (out_k < KW'(SIDE)) && (in_line < LW'(LINES))
      && (out_line < LW'(LINES)))
    else $error("bank phase counter out of range");

endmodule

@@ sv/mwf_window.sv @@
// mwf_window: line store banks and gathering of one result's window
module mwf_window #(
  parameter int RADIUS = 1,
  parameter int MAX_WIDTH = 1024,
  localparam int SIDE = 2 * RADIUS + 1,
  localparam int LINES = 4 * RADIUS + 2,
  localparam int WIN = SIDE * SIDE,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = CW + 1,
  localparam int KW = $clog2(SIDE),
  localparam int LW = $clog2(LINES),
  localparam int DEPTH = (MAX_WIDTH + SIDE - 1) / SIDE,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          wr_en,
  input  logic [LW-1:0]                 wr_line,
  input  logic [KW-1:0]                 wr_k,
  input  logic [AW-1:0]                 wr_addr,
  input  mwf_pkg::pixel_t               wr_data,
  input  logic                          pos_valid,
  input  logic [mwf_pkg::OUT_ROW_W-1:0] pos_row,
  input  logic [CW-1:0]                 pos_col,
  input  logic [AW-1:0]                 pos_q,
  input  logic [KW-1:0]                 pos_k,
  input  logic [LW-1:0]                 pos_line,
  input  mwf_pkg::mwf_flags_t           pos_flags,
  input  logic [WW-1:0]                 w_eff,
  input  logic [mwf_pkg::HEIGHT_W-1:0]  h_eff,
  output logic                          win_valid,
  output mwf_pkg::pixel_t               win [WIN],
  output logic                          win_ok [WIN],
  output mwf_pkg::mwf_flags_t           win_flags
);
  import mwf_pkg::*;

  logic [KW-1:0] col_k [SIDE];
  logic [AW-1:0] col_q [SIDE];
  logic          col_ok [SIDE];
  logic [LW-1:0] row_line [SIDE];
  logic          row_ok [SIDE];
  logic [AW-1:0] bank_addr [SIDE];
  pixel_t        bank_q [LINES][SIDE];

  logic [KW-1:0] sel_k [SIDE];
  logic          sel_col_ok [SIDE];
  logic [LW-1:0] sel_line [SIDE];
  logic          sel_row_ok [SIDE];

  // columns c-R..c+R fall in distinct banks; fix up quotient across the bank wrap
  always_comb begin
    logic [KW+1:0] t;
    logic [CW+1:0] cp;
    logic [LW+1:0] lt;
    logic [13:0]   rp;
    for (int d = 0; d < SIDE; d++) begin
      t  = {2'b00, pos_k} + (KW+2)'(d);
      cp = {2'b00, pos_col} + (CW+2)'(d);
      if (t < (KW+2)'(RADIUS)) begin
        col_k[d] = KW'(t + (KW+2)'(SIDE - RADIUS));
        col_q[d] = pos_q - AW'(1);
      end else if (t >= (KW+2)'(SIDE + RADIUS)) begin
        col_k[d] = KW'(t - (KW+2)'(SIDE + RADIUS));
        col_q[d] = pos_q + AW'(1);
      end else begin
        col_k[d] = KW'(t - (KW+2)'(RADIUS));
        col_q[d] = pos_q;
      end
      col_ok[d] = (cp >= (CW+2)'(RADIUS)) && (cp - (CW+2)'(RADIUS) < {1'b0, w_eff});

      lt = {2'b00, pos_line} + (LW+2)'(d);
      rp = {2'b00, pos_row} + 14'(d);
      if (lt < (LW+2)'(RADIUS)) begin
        row_line[d] = LW'(lt + (LW+2)'(LINES - RADIUS));
      end else if (lt >= (LW+2)'(LINES + RADIUS)) begin
        row_line[d] = LW'(lt - (LW+2)'(LINES + RADIUS));
      end else begin
        row_line[d] = LW'(lt - (LW+2)'(RADIUS));
      end
      row_ok[d] = (rp >= 14'(RADIUS)) && (rp - 14'(RADIUS) < {1'b0, h_eff});
    end
    for (int k = 0; k < SIDE; k++) begin
      bank_addr[k] = '0;
      for (int d = 0; d < SIDE; d++) begin
        if (col_k[d] == KW'(k)) begin
          bank_addr[k] = col_q[d];
        end
      end
    end
  end

  for (genvar l = 0; l < LINES; l++) begin : g_line
    for (genvar k = 0; k < SIDE; k++) begin : g_bank
      mwf_line_bank #(.DEPTH(DEPTH)) u_bank (
        .clk   (clk),
        .we    (wr_en && wr_line == LW'(l) && wr_k == KW'(k)),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (adv),
        .raddr (bank_addr[k]),
        .rdata (bank_q[l][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (adv) begin
      win_valid <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_k      <= col_k;
      sel_col_ok <= col_ok;
      sel_line   <= row_line;
      sel_row_ok <= row_ok;
      win_flags  <= pos_flags;
    end
  end

  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        win[r * SIDE + c]    = bank_q[sel_line[r]][sel_k[c]];
        win_ok[r * SIDE + c] = sel_row_ok[r] && sel_col_ok[c];
      end
    end
  end

endmodule

@@ sv/mwf_median.sv @@
// mwf_median: rank-based median of the valid window samples and the result register
module mwf_median #(
  parameter int RADIUS = 1,
  localparam int SIDE = 2 * RADIUS + 1,
  localparam int WIN = SIDE * SIDE,
  localparam int RKW = $clog2(WIN),
  localparam int CNW = $clog2(WIN + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                win_valid,
  input  mwf_pkg::pixel_t     win [WIN],
  input  logic                win_ok [WIN],
  input  mwf_pkg::mwf_flags_t win_flags,
  output logic                res_valid,
  output mwf_pkg::pixel_t     res_filtered,
  output mwf_pkg::mwf_flags_t res_flags
);
  import mwf_pkg::*;

  logic [8:0]     key [WIN];
  logic [RKW-1:0] rank_next [WIN];
  logic [CNW-1:0] cnt_next;

  logic           rk_valid;
  pixel_t         rk_val [WIN];
  logic [RKW-1:0] rk_rank [WIN];
  logic [CNW-1:0] rk_cnt;
  mwf_flags_t     rk_flags;

  logic [CNW-1:0] half;
  pixel_t         hi;
  pixel_t         lo;
  logic [8:0]     sum;

  // dropped samples sort above every real one; ties broken by position
  always_comb begin
    cnt_next = '0;
    for (int i = 0; i < WIN; i++) begin
      key[i] = win_ok[i] ? {1'b0, win[i]} : 9'h100;
      cnt_next = cnt_next + CNW'(win_ok[i]);
    end
    for (int i = 0; i < WIN; i++) begin
      rank_next[i] = '0;
      for (int j = 0; j < WIN; j++) begin
        if (j != i && (key[j] < key[i] || (key[j] == key[i] && j < i))) begin
          rank_next[i] = rank_next[i] + RKW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rk_valid <= 1'b0;
    end else if (adv) begin
      rk_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < WIN; i++) begin
        rk_val[i]  <= key[i][7:0];
        rk_rank[i] <= rank_next[i];
      end
      rk_cnt   <= cnt_next;
      rk_flags <= win_flags;
    end
  end

  // odd count averages the middle value with itself
  always_comb begin
    half = rk_cnt >> 1;
    hi   = '0;
    lo   = '0;
    for (int i = 0; i < WIN; i++) begin
      if (CNW'(rk_rank[i]) == half) begin
        hi = hi | rk_val[i];
      end
      if (CNW'(rk_rank[i]) + CNW'(1) == half) begin
        lo = lo | rk_val[i];
      end
    end
    sum = {1'b0, hi} + {1'b0, (rk_cnt[0] ? hi : lo)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= rk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_filtered <= sum[8:1];
      res_flags    <= rk_flags;
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    rk_valid |-> (rk_cnt != '0))
    else $error("window without samples");
  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    (adv && rk_valid) |=> res_valid)
    else $error("ranked window lost on the way to the result register");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!adv && res_valid) |=> (res_valid && $stable(res_filtered)))
    else $error("result changed while stalled");

endmodule

@@ sv/median_window_filter.sv @@
// median_window_filter: streaming median over a (2*RADIUS+1) square window, border shrink
//
//   channel   dir   payload                              beat when
//   pixels    in    sample, drain                        valid && ready
//   results   out   filtered, line_end, frame_end        valid && ready
//   cfg       in    index (0 width, 1 height), data      valid && ready (ready tied high)
//
// one item per clock while not stalled; registers: input, position, window, rank, result
// the line store is split into 4*RADIUS+2 rows by 2*RADIUS+1 column phases, so all
// window samples are read in the same cycle, one read per bank
// the whole pipeline holds while a result waits on results.ready; pixels.ready follows
// reset clears counters and valid bits; line store contents need no clearing
module median_window_filter #(
  parameter int RADIUS = 1,
  parameter int MAX_WIDTH = 1024
) (
  input  logic      clk,
  input  logic      rst,
  mwf_pix_if.sink   pixels,
  mwf_res_if.source results,
  mwf_cfg_if.sink   cfg
);
  import mwf_pkg::*;

  localparam int SIDE = 2 * RADIUS + 1;
  localparam int LINES = 4 * RADIUS + 2;
  localparam int WIN = SIDE * SIDE;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int KW = $clog2(SIDE);
  localparam int LW = $clog2(LINES);
  localparam int DEPTH = (MAX_WIDTH + SIDE - 1) / SIDE;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                 adv;
  logic                 s0_valid;
  pixel_t               s0_sample;
  logic                 s0_drain;

  logic                 wr_en;
  logic [LW-1:0]        wr_line;
  logic [KW-1:0]        wr_k;
  logic [AW-1:0]        wr_addr;
  pixel_t               wr_data;
  logic                 pos_valid;
  logic [OUT_ROW_W-1:0] pos_row;
  logic [CW-1:0]        pos_col;
  logic [AW-1:0]        pos_q;
  logic [KW-1:0]        pos_k;
  logic [LW-1:0]        pos_line;
  mwf_flags_t           pos_flags;
  logic [WW-1:0]        w_eff;
  logic [HEIGHT_W-1:0]  h_eff;

  logic                 win_valid;
  pixel_t               win [WIN];
  logic                 win_ok [WIN];
  mwf_flags_t           win_flags;

  logic                 res_valid;
  pixel_t               res_filtered;
  mwf_flags_t           res_flags;

  assign adv          = !res_valid || results.ready;
  assign pixels.ready = adv;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sample <= pixels.sample;
      s0_drain  <= pixels.drain;
    end
  end

  mwf_ctrl #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .item_valid  (s0_valid),
    .item_sample (s0_sample),
    .item_drain  (s0_drain),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .wr_en       (wr_en),
    .wr_line     (wr_line),
    .wr_k        (wr_k),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .pos_valid   (pos_valid),
    .pos_row     (pos_row),
    .pos_col     (pos_col),
    .pos_q       (pos_q),
    .pos_k       (pos_k),
    .pos_line    (pos_line),
    .pos_flags   (pos_flags),
    .w_eff       (w_eff),
    .h_eff       (h_eff)
  );

  mwf_window #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .wr_en     (wr_en),
    .wr_line   (wr_line),
    .wr_k      (wr_k),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .pos_valid (pos_valid),
    .pos_row   (pos_row),
    .pos_col   (pos_col),
    .pos_q     (pos_q),
    .pos_k     (pos_k),
    .pos_line  (pos_line),
    .pos_flags (pos_flags),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .win_valid (win_valid),
    .win       (win),
    .win_ok    (win_ok),
    .win_flags (win_flags)
  );

  mwf_median #(.RADIUS(RADIUS)) u_median (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .win_valid    (win_valid),
    .win          (win),
    .win_ok       (win_ok),
    .win_flags    (win_flags),
    .res_valid    (res_valid),
    .res_filtered (res_filtered),
    .res_flags    (res_flags)
  );

  assign results.valid     = res_valid;
  assign results.filtered  = res_filtered;
  assign results.line_end  = res_flags.line_end;
  assign results.frame_end = res_flags.frame_end;

endmodule
